/* src/hwns_pkg.sv */
// ----------------------------------------------------------------------------
// hwns_pkg
// shared constants, register map and stage control type of the hit window
// nearest search unit
// ----------------------------------------------------------------------------
package hwns_pkg;

  // default geometry
  localparam int unsigned COORD_BITS_DEF = 24;
  localparam int unsigned ID_BITS_DEF    = 16;

  // window half width in units of the projected error
  localparam int unsigned WINDOW_SIGMAS = 5;

  // register port
  localparam int unsigned NUM_REGS      = 6;
  localparam int unsigned APB_DATA_BITS = 32;
  localparam int unsigned APB_ADDR_BITS = $clog2(4 * NUM_REGS);
  localparam int unsigned REG_IDX_BITS  = APB_ADDR_BITS - 2;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_TRACK_X   = 3'd0,
    REG_TRACK_Y   = 3'd1,
    REG_TRACK_Z   = 3'd2,
    REG_ERROR_Y   = 3'd3,
    REG_ERROR_Z   = 3'd4,
    REG_WINDOW_EN = 3'd5
  } reg_idx_e;

  // control that travels with an item from the geometry stages to selection
  typedef struct packed {
    logic valid;
    logic cand;
    logic first;
  } stage_ctrl_t;

  // round a bit count up to whole bytes
  function automatic int unsigned byte_pad(input int unsigned bits);
    return ((bits + 7) / 8) * 8;
  endfunction

endpackage

/* src/hwns_cfg_regs.sv */
// ----------------------------------------------------------------------------
// hwns_cfg_regs
// register file behind the apb port: track point, errors, window enable
// ----------------------------------------------------------------------------
module hwns_cfg_regs #(
  parameter int unsigned COORD_BITS = hwns_pkg::COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hwns_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [hwns_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [hwns_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                pready,
  output logic signed [COORD_BITS-1:0]        track_x_o,
  output logic signed [COORD_BITS-1:0]        track_y_o,
  output logic signed [COORD_BITS-1:0]        track_z_o,
  output logic [COORD_BITS-2:0]               error_y_o,
  output logic [COORD_BITS-2:0]               error_z_o,
  output logic                                window_en_o
);
  import hwns_pkg::*;

  logic signed [COORD_BITS-1:0] track_x_q, track_y_q, track_z_q;
  logic [COORD_BITS-2:0]        error_y_q, error_z_q;
  logic                         window_en_q;
  logic                         wr_en;
  reg_idx_e                     idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[APB_ADDR_BITS-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_x_q   <= '0;
      track_y_q   <= '0;
      track_z_q   <= '0;
      error_y_q   <= '0;
      error_z_q   <= '0;
      window_en_q <= 1'b1;
    end else if (wr_en) begin
      case (idx)
        REG_TRACK_X:   track_x_q   <= pwdata[COORD_BITS-1:0];
        REG_TRACK_Y:   track_y_q   <= pwdata[COORD_BITS-1:0];
        REG_TRACK_Z:   track_z_q   <= pwdata[COORD_BITS-1:0];
        REG_ERROR_Y:   error_y_q   <= pwdata[COORD_BITS-2:0];
        REG_ERROR_Z:   error_z_q   <= pwdata[COORD_BITS-2:0];
        REG_WINDOW_EN: window_en_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TRACK_X:   prdata = APB_DATA_BITS'($unsigned(track_x_q));
      REG_TRACK_Y:   prdata = APB_DATA_BITS'($unsigned(track_y_q));
      REG_TRACK_Z:   prdata = APB_DATA_BITS'($unsigned(track_z_q));
      REG_ERROR_Y:   prdata = APB_DATA_BITS'(error_y_q);
      REG_ERROR_Z:   prdata = APB_DATA_BITS'(error_z_q);
      REG_WINDOW_EN: prdata = APB_DATA_BITS'(window_en_q);
      default:       prdata = '0;
    endcase
  end

  assign track_x_o   = track_x_q;
  assign track_y_o   = track_y_q;
  assign track_z_o   = track_z_q;
  assign error_y_o   = error_y_q;
  assign error_z_o   = error_z_q;
  assign window_en_o = window_en_q;

endmodule

/* src/hwns_geom.sv */
// ----------------------------------------------------------------------------
// hwns_geom
// input register, per-axis offset magnitude with window test, then squares
// ----------------------------------------------------------------------------
module hwns_geom #(
  parameter int unsigned COORD_BITS = hwns_pkg::COORD_BITS_DEF,
  parameter int unsigned ID_BITS    = hwns_pkg::ID_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_valid_i,
  output logic                              s_ready_o,
  input  logic signed [COORD_BITS-1:0]      hit_x_i,
  input  logic signed [COORD_BITS-1:0]      hit_y_i,
  input  logic signed [COORD_BITS-1:0]      hit_z_i,
  input  logic [ID_BITS-1:0]                hit_id_i,
  input  logic                              first_hit_i,
  input  logic signed [COORD_BITS-1:0]      track_x_i,
  input  logic signed [COORD_BITS-1:0]      track_y_i,
  input  logic signed [COORD_BITS-1:0]      track_z_i,
  input  logic [COORD_BITS-2:0]             error_y_i,
  input  logic [COORD_BITS-2:0]             error_z_i,
  input  logic                              window_en_i,
  input  logic                              ready_i,
  output hwns_pkg::stage_ctrl_t             ctrl_o,
  output logic [2*(COORD_BITS+1)-1:0]       sq_x_o,
  output logic [2*(COORD_BITS+1)-1:0]       sq_y_o,
  output logic [2*(COORD_BITS+1)-1:0]       sq_z_o,
  output logic [ID_BITS-1:0]                id_o
);
  import hwns_pkg::*;

  localparam int unsigned DB = COORD_BITS + 1;   // offset and magnitude
  localparam int unsigned LB = COORD_BITS + 2;   // window limit
  localparam int unsigned SB = 2 * DB;           // square

  // stage 1: input register
  logic                         v1_q, first1_q;
  logic signed [COORD_BITS-1:0] hx1_q, hy1_q, hz1_q;
  logic [ID_BITS-1:0]           id1_q;
  // stage 2: magnitudes and window flag
  logic                         v2_q, first2_q, cand2_q;
  logic [DB-1:0]                mx2_q, my2_q, mz2_q;
  logic [ID_BITS-1:0]           id2_q;
  // stage 3: squares
  logic                         v3_q, first3_q, cand3_q;
  logic [SB-1:0]                sqx3_q, sqy3_q, sqz3_q;
  logic [ID_BITS-1:0]           id3_q;

  logic                         rdy1, rdy2, rdy3;
  logic signed [DB-1:0]         dx, dy, dz;
  logic [DB-1:0]                mx, my, mz;
  logic [LB-1:0]                lim_y, lim_z;
  logic                         cand;

  assign rdy3      = !v3_q || ready_i;
  assign rdy2      = !v2_q || rdy3;
  assign rdy1      = !v1_q || rdy2;
  assign s_ready_o = rdy1;

  // offset is track minus hit
  always_comb begin
    dx    = DB'(track_x_i) - DB'(hx1_q);
    dy    = DB'(track_y_i) - DB'(hy1_q);
    dz    = DB'(track_z_i) - DB'(hz1_q);
    mx    = dx[DB-1] ? $unsigned(-dx) : $unsigned(dx);
    my    = dy[DB-1] ? $unsigned(-dy) : $unsigned(dy);
    mz    = dz[DB-1] ? $unsigned(-dz) : $unsigned(dz);
    lim_y = LB'(error_y_i) * LB'(WINDOW_SIGMAS);
    lim_z = LB'(error_z_i) * LB'(WINDOW_SIGMAS);
    cand  = !window_en_i || ((LB'(my) < lim_y) && (LB'(mz) < lim_z));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= s_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && s_valid_i) begin
      hx1_q    <= hit_x_i;
      hy1_q    <= hit_y_i;
      hz1_q    <= hit_z_i;
      id1_q    <= hit_id_i;
      first1_q <= first_hit_i;
    end
    if (rdy2 && v1_q) begin
      mx2_q    <= mx;
      my2_q    <= my;
      mz2_q    <= mz;
      cand2_q  <= cand;
      id2_q    <= id1_q;
      first2_q <= first1_q;
    end
    if (rdy3 && v2_q) begin
      sqx3_q   <= SB'(mx2_q) * SB'(mx2_q);
      sqy3_q   <= SB'(my2_q) * SB'(my2_q);
      sqz3_q   <= SB'(mz2_q) * SB'(mz2_q);
      cand3_q  <= cand2_q;
      id3_q    <= id2_q;
      first3_q <= first2_q;
    end
  end

  assign ctrl_o = '{valid: v3_q, cand: cand3_q, first: first3_q};
  assign sq_x_o = sqx3_q;
  assign sq_y_o = sqy3_q;
  assign sq_z_o = sqz3_q;
  assign id_o   = id3_q;

endmodule

/* src/hwns_select.sv */
// ----------------------------------------------------------------------------
// hwns_select
// distance sum, nearest-hit compare against the running best, result register
// ----------------------------------------------------------------------------
module hwns_select #(
  parameter int unsigned COORD_BITS = hwns_pkg::COORD_BITS_DEF,
  parameter int unsigned ID_BITS    = hwns_pkg::ID_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hwns_pkg::stage_ctrl_t         ctrl_i,
  output logic                          ready_o,
  input  logic [2*(COORD_BITS+1)-1:0]   sq_x_i,
  input  logic [2*(COORD_BITS+1)-1:0]   sq_y_i,
  input  logic [2*(COORD_BITS+1)-1:0]   sq_z_i,
  input  logic [ID_BITS-1:0]            id_i,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic                          in_window_o,
  output logic                          new_nearest_o,
  output logic                          nearest_valid_o,
  output logic [ID_BITS-1:0]            nearest_id_o
);
  import hwns_pkg::*;

  localparam int unsigned SB = 2 * (COORD_BITS + 1);
  localparam int unsigned DB = SB + 2;

  // stage 4: distance sum
  logic               v4_q, cand4_q, first4_q;
  logic [DB-1:0]      sum4_q;
  logic [ID_BITS-1:0] id4_q;
  // running best
  logic [DB-1:0]      best_dist_q, best_dist_d;
  logic [ID_BITS-1:0] best_id_q, best_id_d;
  logic               best_valid_q, best_valid_d;
  // result register
  logic               ov_q, iw_q, nn_q, nv_q;
  logic [ID_BITS-1:0] nid_q;

  logic               rdy4, rdy5, adv5;
  logic               base_valid, took;

  assign rdy5    = !ov_q || m_ready_i;
  assign rdy4    = !v4_q || rdy5;
  assign ready_o = rdy4;
  assign adv5    = v4_q && rdy5;

  // a first hit clears the set before this hit competes
  always_comb begin
    base_valid   = first4_q ? 1'b0 : best_valid_q;
    took         = cand4_q && (!base_valid || (sum4_q < best_dist_q));
    best_valid_d = took || base_valid;
    best_dist_d  = took ? sum4_q : best_dist_q;
    if (took) begin
      best_id_d = id4_q;
    end else if (first4_q) begin
      best_id_d = '0;
    end else begin
      best_id_d = best_id_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q         <= 1'b0;
      ov_q         <= 1'b0;
      best_dist_q  <= '0;
      best_id_q    <= '0;
      best_valid_q <= 1'b0;
    end else begin
      if (rdy4) begin
        v4_q <= ctrl_i.valid;
      end
      if (rdy5) begin
        ov_q <= v4_q;
      end
      if (adv5) begin
        best_dist_q  <= best_dist_d;
        best_id_q    <= best_id_d;
        best_valid_q <= best_valid_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && ctrl_i.valid) begin
      sum4_q   <= DB'(sq_x_i) + DB'(sq_y_i) + DB'(sq_z_i);
      id4_q    <= id_i;
      cand4_q  <= ctrl_i.cand;
      first4_q <= ctrl_i.first;
    end
    if (adv5) begin
      iw_q  <= cand4_q;
      nn_q  <= took;
      nv_q  <= best_valid_d;
      nid_q <= best_id_d;
    end
  end

  assign m_valid_o       = ov_q;
  assign in_window_o     = iw_q;
  assign new_nearest_o   = nn_q;
  assign nearest_valid_o = nv_q;
  assign nearest_id_o    = nid_q;

  // a hit taken as nearest must have been a candidate and leaves a valid best
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && nn_q |-> iw_q && nv_q)
    else $error("new nearest without candidate or valid best");

  // no nearest yet reads as id zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !nv_q |-> nid_q == '0)
    else $error("nearest id not zero while no nearest");

  // the best is only dropped by a first hit that found no candidate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(best_valid_q) |-> $past(adv5 && first4_q && !took))
    else $error("best hit lost without a first hit");

  // the best only changes when an item passes into the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(adv5) |-> $stable(best_id_q) && $stable(best_valid_q))
    else $error("best hit changed without an item");

endmodule

/* src/hit_window_nearest_search_unit.sv */
// ----------------------------------------------------------------------------
// hit_window_nearest_search_unit
// compares a stream of hits against one track point, flags hits inside the
// five-sigma window and keeps the nearest hit by squared 3-d distance
// ----------------------------------------------------------------------------
// path: the input register loads at the input handshake and four more registers
//   follow before the result appears on m_axis
// throughput: one item per cycle unless m_axis_tready stalls; the only loop is
//   the distance compare against the running best, which never holds items back
// stall: the ready chain through the five stage registers lets bubbles close up
// reset: async, active low; config registers go to zero with window enable set, the
//   pipeline empties and the running best is cleared
module hit_window_nearest_search_unit #(
  parameter int unsigned COORD_BITS = hwns_pkg::COORD_BITS_DEF,
  parameter int unsigned ID_BITS    = hwns_pkg::ID_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hwns_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [hwns_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [hwns_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                pready,
  // hit items
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // hit_x, hit_y, hit_z, hit_id (low bit up), zero filled to whole bytes
  input  logic [hwns_pkg::byte_pad(3*COORD_BITS+ID_BITS)-1:0] s_axis_tdata,
  // first_hit
  input  logic                                s_axis_tuser,
  // result items
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // in_window, new_nearest, nearest_valid, nearest_id (low bit up), zero filled
  output logic [hwns_pkg::byte_pad(3+ID_BITS)-1:0] m_axis_tdata
);
  import hwns_pkg::*;

  localparam int unsigned SB       = 2 * (COORD_BITS + 1);
  localparam int unsigned OUT_BITS = byte_pad(3 + ID_BITS);

  // configuration
  logic signed [COORD_BITS-1:0] track_x, track_y, track_z;
  logic [COORD_BITS-2:0]        error_y, error_z;
  logic                         window_en;

  // geometry to selection
  stage_ctrl_t                  geo_ctrl;
  logic                         sel_ready;
  logic [SB-1:0]                sq_x, sq_y, sq_z;
  logic [ID_BITS-1:0]           geo_id;

  // results
  logic                         in_window, new_nearest, nearest_valid;
  logic [ID_BITS-1:0]           nearest_id;

  hwns_cfg_regs #(
    .COORD_BITS (COORD_BITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .track_x_o   (track_x),
    .track_y_o   (track_y),
    .track_z_o   (track_z),
    .error_y_o   (error_y),
    .error_z_o   (error_z),
    .window_en_o (window_en)
  );

  // stages 1-3: input register, offsets with window test, squares
  hwns_geom #(
    .COORD_BITS (COORD_BITS),
    .ID_BITS    (ID_BITS)
  ) u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .hit_x_i     (s_axis_tdata[COORD_BITS-1:0]),
    .hit_y_i     (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .hit_z_i     (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .hit_id_i    (s_axis_tdata[3*COORD_BITS+ID_BITS-1:3*COORD_BITS]),
    .first_hit_i (s_axis_tuser),
    .track_x_i   (track_x),
    .track_y_i   (track_y),
    .track_z_i   (track_z),
    .error_y_i   (error_y),
    .error_z_i   (error_z),
    .window_en_i (window_en),
    .ready_i     (sel_ready),
    .ctrl_o      (geo_ctrl),
    .sq_x_o      (sq_x),
    .sq_y_o      (sq_y),
    .sq_z_o      (sq_z),
    .id_o        (geo_id)
  );

  // stages 4-5: distance sum, nearest compare, result register
  hwns_select #(
    .COORD_BITS (COORD_BITS),
    .ID_BITS    (ID_BITS)
  ) u_select (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (geo_ctrl),
    .ready_o         (sel_ready),
    .sq_x_i          (sq_x),
    .sq_y_i          (sq_y),
    .sq_z_i          (sq_z),
    .id_i            (geo_id),
    .m_valid_o       (m_axis_tvalid),
    .m_ready_i       (m_axis_tready),
    .in_window_o     (in_window),
    .new_nearest_o   (new_nearest),
    .nearest_valid_o (nearest_valid),
    .nearest_id_o    (nearest_id)
  );

  // pack the result item, first field in the low bits
  assign m_axis_tdata = OUT_BITS'({nearest_id, nearest_valid, new_nearest, in_window});

endmodule
